// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the handle table.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define PTH_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("handle table assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PTH_ASSERT_SAME(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("handle table assertion failed");

`endif

// ===== design/pth_pkg.sv =====
// Shared types, codes and constants of the packet type handle table.
// No dependencies.
`default_nettype none

package pth_pkg;

   localparam int NUM_HANDLES_DEF = 16;
   localparam int TYPE_BYTES_DEF  = 8;

   localparam int OP_W      = 2;
   localparam int CLASS_W   = 8;
   localparam int IFTYPE_W  = 16;
   localparam int IFNUM_W   = 8;
   localparam int TLEN_W    = 16;
   localparam int TBYTES_W  = 64;
   localparam int HANDLE_W  = 4;
   localparam int STATUS_W  = 4;
   localparam int COUNT_W   = 5;
   localparam int ELEN_W    = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   localparam logic [IFTYPE_W-1:0] ANY_TYPE = 16'hFFFF;

   localparam logic [CLASS_W-1:0]  OWN_CLASS_RST  = 8'd1;
   localparam logic [IFTYPE_W-1:0] OWN_TYPE_RST   = 16'd0;
   localparam logic [CLASS_W-1:0]  IEEE_CLASS_RST = 8'd11;

   localparam logic [CSR_IDX_W-1:0] CSR_OWN_CLASS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OWN_TYPE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IEEE_CLASS = 2'd2;

   typedef enum logic [OP_W-1:0] {
      OP_ACCESS  = 2'd0,
      OP_RELEASE = 2'd1,
      OP_LOCATE  = 2'd2,
      OP_VERIFY  = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 4'd0,
      ST_NO_CLASS   = 4'd1,
      ST_NO_TYPE    = 4'd2,
      ST_NO_NUMBER  = 4'd3,
      ST_BAD_TYPE   = 4'd4,
      ST_NO_SPACE   = 4'd5,
      ST_TYPE_INUSE = 4'd6,
      ST_BAD_HANDLE = 4'd7,
      ST_NOT_FOUND  = 4'd8
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EVAL = 1'b1
   } ctrl_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic capture;
      logic commit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic out_busy;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/pth_ifs.sv =====
// Valid/ready channel interfaces for requests and responses of the handle table.
// Depends on pth_pkg for field widths.
`default_nettype none

interface pth_req_if;
   logic                             valid;
   logic                             ready;
   logic [pth_pkg::OP_W-1:0]         op;
   logic [pth_pkg::CLASS_W-1:0]      pkt_class;
   logic [pth_pkg::IFTYPE_W-1:0]     if_type;
   logic [pth_pkg::IFNUM_W-1:0]      if_number;
   logic [pth_pkg::TLEN_W-1:0]       type_len;
   logic [pth_pkg::TBYTES_W-1:0]     type_bytes;
   logic [pth_pkg::HANDLE_W-1:0]     handle_in;
   logic                             receiver_present;

   modport source (output valid, op, pkt_class, if_type, if_number, type_len,
                   type_bytes, handle_in, receiver_present, input ready);
   modport sink   (input valid, op, pkt_class, if_type, if_number, type_len,
                   type_bytes, handle_in, receiver_present, output ready);
endinterface

interface pth_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pth_pkg::STATUS_W-1:0]     status;
   logic [pth_pkg::HANDLE_W-1:0]     handle_out;
   logic [pth_pkg::COUNT_W-1:0]      active_count;

   modport source (output valid, status, handle_out, active_count, input ready);
   modport sink   (input valid, status, handle_out, active_count, output ready);
endinterface

`default_nettype wire

// ===== design/packet_type_handle_table_unit.sv =====
// Top level of the packet type handle table; joins pth_ctrl and pth_dp.
// Depends on pth_pkg and the channel interfaces in pth_ifs.sv.
`default_nettype none

// Packet type handle table. Each request transaction (access, release,
// locate, verify) passes through an accept state and an evaluate state:
// the request is latched on the accepting edge, and in evaluate every
// table entry is compared in parallel, a priority pick chooses the slot,
// the table and the used count are updated and the result is loaded into
// the response register. A new request is taken only from the cycle after
// commit on, even while the response register still holds an untaken
// result. If the previous result is still waiting when a request finishes
// evaluation, the block holds in evaluate until the response side takes
// it. The used flags reset at once, so no clearing pass follows reset.
// Configuration writes take effect at the edge of csr_we and must be made
// only while no request is in flight.
module packet_type_handle_table_unit #(
   parameter int NUM_HANDLES = pth_pkg::NUM_HANDLES_DEF,
   parameter int TYPE_BYTES  = pth_pkg::TYPE_BYTES_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   pth_req_if.sink                            req_chan,
   pth_rsp_if.source                          rsp_chan,
   input  wire logic                          csr_we,
   input  wire logic [pth_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [pth_pkg::CSR_DAT_W-1:0] csr_wdata
);

   pth_pkg::cmd_type  cmd;
   pth_pkg::stat_type stat;

   // sequencer: idle/accept, then evaluate and commit
   pth_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // table, compare logic and response register
   pth_dp #(
      .NUM_HANDLES (NUM_HANDLES),
      .TYPE_BYTES  (TYPE_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .op               (req_chan.op),
      .pkt_class        (req_chan.pkt_class),
      .if_type          (req_chan.if_type),
      .if_number        (req_chan.if_number),
      .type_len         (req_chan.type_len),
      .type_bytes       (req_chan.type_bytes),
      .handle_in        (req_chan.handle_in),
      .receiver_present (req_chan.receiver_present),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_handle       (rsp_chan.handle_out),
      .rsp_count        (rsp_chan.active_count)
   );

endmodule

`default_nettype wire

// ===== design/pth_ctrl.sv =====
// Controller of the handle table: accept, evaluate, commit sequencing.
// Depends on pth_pkg.
`default_nettype none

module pth_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pth_pkg::stat_type stat,
   output pth_pkg::cmd_type       cmd
);

   pth_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pth_pkg::CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pth_pkg::CS_IDLE: begin
            if (req_valid) state_in = pth_pkg::CS_EVAL;
         end
         pth_pkg::CS_EVAL: begin
            if (!stat.out_busy) state_in = pth_pkg::CS_IDLE;
         end
         default: state_in = pth_pkg::CS_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      unique case (state_ff)
         pth_pkg::CS_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         pth_pkg::CS_EVAL: begin
            // hold until the response register can take the result
            cmd.commit = !stat.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/pth_dp.sv =====
// Datapath of the handle table: request latch, entry registers, parallel
// compare and priority pick, config registers, response register. Uses pth_pkg.
`default_nettype none

module pth_dp #(
   parameter int NUM_HANDLES = pth_pkg::NUM_HANDLES_DEF,
   parameter int TYPE_BYTES  = pth_pkg::TYPE_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire pth_pkg::cmd_type                cmd,
   output pth_pkg::stat_type                    stat,
   input  wire logic [pth_pkg::OP_W-1:0]        op,
   input  wire logic [pth_pkg::CLASS_W-1:0]     pkt_class,
   input  wire logic [pth_pkg::IFTYPE_W-1:0]    if_type,
   input  wire logic [pth_pkg::IFNUM_W-1:0]     if_number,
   input  wire logic [pth_pkg::TLEN_W-1:0]      type_len,
   input  wire logic [pth_pkg::TBYTES_W-1:0]    type_bytes,
   input  wire logic [pth_pkg::HANDLE_W-1:0]    handle_in,
   input  wire logic                            receiver_present,
   input  wire logic                            csr_we,
   input  wire logic [pth_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [pth_pkg::CSR_DAT_W-1:0]   csr_wdata,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [pth_pkg::STATUS_W-1:0]         rsp_status,
   output logic [pth_pkg::HANDLE_W-1:0]         rsp_handle,
   output logic [pth_pkg::COUNT_W-1:0]          rsp_count
);

   localparam int TW  = 8 * TYPE_BYTES;
   localparam int IW  = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
   localparam int CNB = $clog2(NUM_HANDLES + 1);
   localparam int CW  = (CNB > pth_pkg::COUNT_W) ? CNB : pth_pkg::COUNT_W;
   localparam int EW  = pth_pkg::ELEN_W;

   function automatic logic [TW-1:0] byte_mask(input logic [EW-1:0] n);
      logic [TW-1:0] m;
      m = '0;
      for (int b = 0; b < TYPE_BYTES; b++) begin
         if (EW'(b) < n) m[8*b +: 8] = 8'hFF;
      end
      return m;
   endfunction

   // configuration
   logic [pth_pkg::CLASS_W-1:0]  own_class_ff;
   logic [pth_pkg::IFTYPE_W-1:0] own_type_ff;
   logic [pth_pkg::CLASS_W-1:0]  ieee_class_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_class_ff  <= pth_pkg::OWN_CLASS_RST;
         own_type_ff   <= pth_pkg::OWN_TYPE_RST;
         ieee_class_ff <= pth_pkg::IEEE_CLASS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pth_pkg::CSR_OWN_CLASS:  own_class_ff  <= csr_wdata[pth_pkg::CLASS_W-1:0];
            pth_pkg::CSR_OWN_TYPE:   own_type_ff   <= csr_wdata[pth_pkg::IFTYPE_W-1:0];
            pth_pkg::CSR_IEEE_CLASS: ieee_class_ff <= csr_wdata[pth_pkg::CLASS_W-1:0];
            default: ;
         endcase
      end
   end

   // request latch
   logic [pth_pkg::OP_W-1:0]     req_op_ff;
   logic [pth_pkg::CLASS_W-1:0]  req_class_ff;
   logic [pth_pkg::IFTYPE_W-1:0] req_type_ff;
   logic [pth_pkg::IFNUM_W-1:0]  req_num_ff;
   logic [pth_pkg::TLEN_W-1:0]   req_len_ff;
   logic [TW-1:0]                req_bytes_ff;
   logic [pth_pkg::HANDLE_W-1:0] req_handle_ff;
   logic                         req_rx_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_op_ff     <= op;
         req_class_ff  <= pkt_class;
         req_type_ff   <= if_type;
         req_num_ff    <= if_number;
         req_len_ff    <= type_len;
         req_bytes_ff  <= type_bytes[TW-1:0];
         req_handle_ff <= handle_in;
         req_rx_ff     <= receiver_present;
      end
   end

   // entry table
   logic [NUM_HANDLES-1:0]      used_ff;
   logic [pth_pkg::CLASS_W-1:0] ent_class_ff [NUM_HANDLES];
   logic [TW-1:0]               ent_type_ff  [NUM_HANDLES];
   logic [EW-1:0]               ent_len_ff   [NUM_HANDLES];
   logic [NUM_HANDLES-1:0]      ent_rx_ff;
   logic [CW-1:0]               count_ff;

   // evaluation
   logic                        len_ok;
   logic [EW-1:0]               len4;
   logic [TW-1:0]               req_mask;
   logic                        conflict;
   logic                        done;
   logic                        full;
   logic [IW-1:0]               free_slot;
   logic                        found;
   logic [IW-1:0]               loc_slot;
   logic                        h_valid;
   logic [IW-1:0]               h_idx;
   logic [EW-1:0]               n_min;
   logic                        cand;
   logic                        loc_hit;
   pth_pkg::status_type         status;
   logic [IW-1:0]               slot;
   logic                        do_claim;
   logic                        do_free;
   logic [CW-1:0]               count_in;

   always_comb begin
      len_ok   = req_len_ff <= pth_pkg::TLEN_W'(TYPE_BYTES);
      len4     = req_len_ff[EW-1:0];
      req_mask = byte_mask(len4);

      // conflict scan: a zero-length overlap ends the scan without a clash
      conflict = 1'b0;
      done     = 1'b0;
      for (int i = 0; i < NUM_HANDLES; i++) begin
         cand  = used_ff[i] && (ent_class_ff[i] == req_class_ff);
         n_min = (ent_len_ff[i] < len4) ? ent_len_ff[i] : len4;
         if (!done && cand) begin
            if (n_min == '0) begin
               done = 1'b1;
            end else if (((ent_type_ff[i] ^ req_bytes_ff) & byte_mask(n_min)) == '0) begin
               conflict = 1'b1;
               done     = 1'b1;
            end
         end
      end

      // lowest free slot
      full      = 1'b1;
      free_slot = '0;
      for (int i = NUM_HANDLES - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            full      = 1'b0;
            free_slot = IW'(i);
         end
      end

      // first matching receiver
      found    = 1'b0;
      loc_slot = '0;
      for (int i = NUM_HANDLES - 1; i >= 0; i--) begin
         loc_hit = used_ff[i] && ent_rx_ff[i]
                && !((ent_class_ff[i] == ieee_class_ff) && (req_class_ff != ieee_class_ff))
                && ((ent_len_ff[i] == '0)
                    || ((ent_class_ff[i] == req_class_ff)
                        && (((ent_type_ff[i] ^ req_bytes_ff)
                             & byte_mask(ent_len_ff[i])) == '0)));
         if (loc_hit) begin
            found    = 1'b1;
            loc_slot = IW'(i);
         end
      end

      h_idx   = IW'(req_handle_ff);
      h_valid = (32'(req_handle_ff) < NUM_HANDLES) && used_ff[h_idx];

      status   = pth_pkg::ST_OK;
      slot     = '0;
      do_claim = 1'b0;
      do_free  = 1'b0;
      case (pth_pkg::op_type'(req_op_ff))
         pth_pkg::OP_ACCESS: begin
            if (own_class_ff == '0 || req_class_ff != own_class_ff) begin
               status = pth_pkg::ST_NO_CLASS;
            end else if (req_type_ff != pth_pkg::ANY_TYPE && req_type_ff != own_type_ff) begin
               status = pth_pkg::ST_NO_TYPE;
            end else if (req_num_ff > pth_pkg::IFNUM_W'(1)) begin
               status = pth_pkg::ST_NO_NUMBER;
            end else if (!len_ok) begin
               status = pth_pkg::ST_BAD_TYPE;
            end else if (conflict) begin
               status = pth_pkg::ST_TYPE_INUSE;
            end else if (full) begin
               status = pth_pkg::ST_NO_SPACE;
            end else begin
               slot     = free_slot;
               do_claim = 1'b1;
            end
         end
         pth_pkg::OP_RELEASE: begin
            if (h_valid) do_free = 1'b1;
            else status = pth_pkg::ST_BAD_HANDLE;
         end
         pth_pkg::OP_LOCATE: begin
            if (found) slot = loc_slot;
            else status = pth_pkg::ST_NOT_FOUND;
         end
         default: begin
            if (!h_valid) status = pth_pkg::ST_BAD_HANDLE;
         end
      endcase

      count_in = count_ff;
      if (do_claim) count_in = count_ff + CW'(1);
      else if (do_free) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         if (do_claim) used_ff[free_slot] <= 1'b1;
         if (do_free)  used_ff[h_idx]     <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && do_claim) begin
         ent_class_ff[free_slot] <= req_class_ff;
         ent_type_ff[free_slot]  <= req_bytes_ff & req_mask;
         ent_len_ff[free_slot]   <= len4;
         ent_rx_ff[free_slot]    <= req_rx_ff;
      end
   end

   // response register
   logic                         rsp_valid_ff;
   logic [pth_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [pth_pkg::HANDLE_W-1:0] rsp_handle_ff;
   logic [pth_pkg::COUNT_W-1:0]  rsp_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status;
         rsp_handle_ff <= pth_pkg::HANDLE_W'(slot);
         rsp_count_ff  <= (count_in > CW'(31)) ? pth_pkg::COUNT_W'(31)
                                               : count_in[pth_pkg::COUNT_W-1:0];
      end
   end

   assign stat.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_handle    = rsp_handle_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

`default_nettype wire

// ===== design/pth_checker.sv =====
// Port-level checker for the handle table, bound to its top level.
// Depends on assert_macros.svh and pth_pkg.
`default_nettype none
`include "assert_macros.svh"

module pth_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [pth_pkg::STATUS_W-1:0] rsp_status
);

   `PTH_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `PTH_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_status))
   `PTH_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)
   `PTH_ASSERT_SAME(a_rsp_after_eval, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

bind packet_type_handle_table_unit pth_checker u_pth_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status)
);

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for packet_type_handle_table_unit: directed and
// random access, release, locate and verify transactions across several
// register settings and flow-control mixes. Depends on pth_pkg and pth_ifs.sv.

module tb;
   import pth_pkg::*;

   localparam int NUM_H          = NUM_HANDLES_DEF;
   localparam int TYPE_B         = TYPE_BYTES_DEF;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int BATCH_ITEMS    = 85;

   typedef struct {
      op_type                op;
      logic [CLASS_W-1:0]    pkt_class;
      logic [IFTYPE_W-1:0]   if_type;
      logic [IFNUM_W-1:0]    if_number;
      logic [TLEN_W-1:0]     type_len;
      logic [TBYTES_W-1:0]   type_bytes;
      logic [HANDLE_W-1:0]   handle_in;
      logic                  receiver_present;
   } table_req_type;

   typedef struct {
      status_type            status;
      logic [HANDLE_W-1:0]   handle;
      logic [COUNT_W-1:0]    active;
   } table_rsp_type;

   logic clock;
   logic reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   pth_req_if req_if();
   pth_rsp_if rsp_if();

   packet_type_handle_table_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Requests waiting to be offered, and responses the table must still return.
   table_req_type request_q[$];
   table_rsp_type expected_rsp_q[$];

   // Shadow copy of the table and its registers.
   logic [CLASS_W-1:0]  cfg_own_class  = OWN_CLASS_RST;
   logic [IFTYPE_W-1:0] cfg_own_type   = OWN_TYPE_RST;
   logic [CLASS_W-1:0]  cfg_ieee_class = IEEE_CLASS_RST;
   bit                  tbl_used[NUM_H];
   logic [CLASS_W-1:0]  tbl_class[NUM_H];
   logic [TBYTES_W-1:0] tbl_type[NUM_H];
   int                  tbl_len[NUM_H];
   bit                  tbl_rx[NUM_H];

   // Flow-control knobs set by the stimulus process, and hold state kept by the monitor.
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int error_count   = 0;
   int rsp_index     = 0;
   int idle_cycles   = 0;
   int status_seen[16];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Mask covering the low n type bytes.
   function automatic logic [TBYTES_W-1:0] prefix_mask(int n);
      if (n >= 8)
         return '1;
      return (64'd1 << (8 * n)) - 64'd1;
   endfunction

   // Apply one request to the shadow table and return the response it must produce.
   function automatic table_rsp_type predict_table_op(table_req_type rq);
      table_rsp_type res;
      int slot;
      int span;
      bit stop;
      int n_used;
      res.status = ST_OK;
      res.handle = '0;
      slot = -1;
      stop = 1'b0;
      n_used = 0;
      case (rq.op)
         OP_ACCESS: begin
            if (cfg_own_class == 0 || rq.pkt_class != cfg_own_class)
               res.status = ST_NO_CLASS;
            else if (rq.if_type != ANY_TYPE && rq.if_type != cfg_own_type)
               res.status = ST_NO_TYPE;
            else if (rq.if_number > 1)
               res.status = ST_NO_NUMBER;
            else if (rq.type_len > TYPE_B)
               res.status = ST_BAD_TYPE;
            else begin
               // Scan same-class entries; a zero common length ends the scan.
               for (int i = 0; i < NUM_H; i++) begin
                  if (!stop && tbl_used[i] && tbl_class[i] == rq.pkt_class) begin
                     span = (tbl_len[i] < int'(rq.type_len)) ? tbl_len[i] : int'(rq.type_len);
                     if (span == 0)
                        stop = 1'b1;
                     else if (((tbl_type[i] ^ rq.type_bytes) & prefix_mask(span)) == '0) begin
                        res.status = ST_TYPE_INUSE;
                        stop = 1'b1;
                     end
                  end
               end
               if (res.status == ST_OK) begin
                  for (int i = NUM_H - 1; i >= 0; i--)
                     if (!tbl_used[i])
                        slot = i;
                  if (slot < 0)
                     res.status = ST_NO_SPACE;
                  else begin
                     tbl_used[slot]  = 1'b1;
                     tbl_class[slot] = rq.pkt_class;
                     tbl_type[slot]  = rq.type_bytes & prefix_mask(int'(rq.type_len));
                     tbl_len[slot]   = int'(rq.type_len);
                     tbl_rx[slot]    = rq.receiver_present;
                     res.handle      = slot[HANDLE_W-1:0];
                  end
               end
            end
         end
         OP_RELEASE: begin
            if (tbl_used[rq.handle_in])
               tbl_used[rq.handle_in] = 1'b0;
            else
               res.status = ST_BAD_HANDLE;
         end
         OP_LOCATE: begin
            res.status = ST_NOT_FOUND;
            for (int i = 0; i < NUM_H; i++) begin
               if (!stop && tbl_used[i] && tbl_rx[i]
                   && !(tbl_class[i] == cfg_ieee_class && rq.pkt_class != cfg_ieee_class)
                   && (tbl_len[i] == 0
                       || (tbl_class[i] == rq.pkt_class
                           && ((tbl_type[i] ^ rq.type_bytes) & prefix_mask(tbl_len[i])) == '0)))
               begin
                  stop       = 1'b1;
                  res.status = ST_OK;
                  res.handle = i[HANDLE_W-1:0];
               end
            end
         end
         default: begin
            if (!tbl_used[rq.handle_in])
               res.status = ST_BAD_HANDLE;
         end
      endcase
      for (int i = 0; i < NUM_H; i++)
         n_used += tbl_used[i];
      res.active = (n_used > 31) ? 5'd31 : n_used[COUNT_W-1:0];
      return res;
   endfunction

   function automatic table_req_type make_req(op_type op, logic [7:0] cls, logic [15:0] typ,
                                              logic [7:0] num, logic [15:0] len,
                                              logic [63:0] bytes, logic [3:0] hdl, logic rx);
      table_req_type rq;
      rq.op               = op;
      rq.pkt_class        = cls;
      rq.if_type          = typ;
      rq.if_number        = num;
      rq.type_len         = len;
      rq.type_bytes       = bytes;
      rq.handle_in        = hdl;
      rq.receiver_present = rx;
      return rq;
   endfunction

   // Bias fields toward the current registers and a small byte alphabet so that
   // claims, prefix clashes and locate hits happen often.
   function automatic table_req_type random_request();
      table_req_type rq;
      int pick;
      pick = $urandom_range(99);
      rq.op = (pick < 38) ? OP_ACCESS : (pick < 60) ? OP_RELEASE :
              (pick < 88) ? OP_LOCATE : OP_VERIFY;
      pick = $urandom_range(99);
      rq.pkt_class = (pick < 70) ? cfg_own_class : (pick < 80) ? cfg_ieee_class :
                     CLASS_W'($urandom_range(255));
      pick = $urandom_range(99);
      rq.if_type = (pick < 45) ? cfg_own_type : (pick < 85) ? ANY_TYPE :
                   IFTYPE_W'($urandom_range(65535));
      rq.if_number = ($urandom_range(99) < 90) ? IFNUM_W'($urandom_range(1)) :
                     IFNUM_W'($urandom_range(255));
      pick = $urandom_range(99);
      rq.type_len = (pick < 90) ? TLEN_W'($urandom_range(TYPE_B)) :
                    (pick < 95) ? TLEN_W'($urandom_range(15, TYPE_B + 1)) :
                    TLEN_W'($urandom_range(65535));
      if ($urandom_range(99) < 70) begin
         for (int b = 0; b < 8; b++)
            rq.type_bytes[8*b +: 8] = 8'($urandom_range(3));
      end else
         rq.type_bytes = {$urandom, $urandom};
      rq.handle_in        = HANDLE_W'($urandom_range(NUM_H - 1));
      rq.receiver_present = ($urandom_range(99) < 80);
      return rq;
   endfunction

   task automatic report_error(string msg);
      $display("ERROR: %s", msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
         report_error($sformatf("response %0d: %s is %0d, expected %0d",
                                rsp_index, name, got, want));
   endtask

   // Write one register; the table must be idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_OWN_CLASS:  cfg_own_class  = val[CLASS_W-1:0];
         CSR_OWN_TYPE:   cfg_own_type   = val[IFTYPE_W-1:0];
         CSR_IEEE_CLASS: cfg_ieee_class = val[CLASS_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Hold until every queued request has gone in and every response has come back.
   task automatic drain();
      while (request_q.size() != 0 || expected_rsp_q.size() != 0)
         @(negedge clock);
   endtask

   // Driver: offer the head of request_q; keep it stable until accepted.
   always @(posedge clock) begin : drive_blk
      bit req_taken;
      req_taken = req_if.valid && req_if.ready;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_taken)
            expected_rsp_q.push_back(predict_table_op(request_q.pop_front()));
         if (req_if.valid && !req_taken) begin
            // hold the pending transaction
         end else if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid            <= 1'b1;
            req_if.op               <= request_q[0].op;
            req_if.pkt_class        <= request_q[0].pkt_class;
            req_if.if_type          <= request_q[0].if_type;
            req_if.if_number        <= request_q[0].if_number;
            req_if.type_len         <= request_q[0].type_len;
            req_if.type_bytes       <= request_q[0].type_bytes;
            req_if.handle_in        <= request_q[0].handle_in;
            req_if.receiver_present <= request_q[0].receiver_present;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted response against the oldest expectation,
   // then decide the next ready, honoring a requested long hold.
   always @(posedge clock) begin : watch_blk
      table_rsp_type want;
      if (rsp_if.valid && rsp_if.ready) begin
         if (expected_rsp_q.size() == 0) begin
            report_error($sformatf("response %0d arrived with nothing outstanding, status %0d",
                                   rsp_index, rsp_if.status));
         end else begin
            want = expected_rsp_q.pop_front();
            check_field("status", {4'b0, rsp_if.status}, {4'b0, want.status});
            check_field("handle_out", {4'b0, rsp_if.handle_out}, {4'b0, want.handle});
            check_field("active_count", {3'b0, rsp_if.active_count}, {3'b0, want.active});
            status_seen[want.status]++;
         end
         rsp_index++;
      end
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
         hold_served++;
         hold_left = HOLD_CYCLES - 1;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      // Drive every input to a known value before the first edge.
      reset                   = 1'b1;
      csr_we                  = 1'b0;
      csr_index               = '0;
      csr_wdata               = '0;
      req_if.valid            = 1'b0;
      req_if.op               = OP_ACCESS;
      req_if.pkt_class        = '0;
      req_if.if_type          = '0;
      req_if.if_number        = '0;
      req_if.type_len         = '0;
      req_if.type_bytes       = '0;
      req_if.handle_in        = '0;
      req_if.receiver_present = 1'b0;
      rsp_if.ready            = 1'b0;
      for (int i = 0; i < 16; i++)
         status_seen[i] = 0;
      for (int i = 0; i < NUM_H; i++)
         tbl_used[i] = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset registers: each reject in check order,
      // prefix clashes, a zero-length claim that ends the scan, stored type masking, locate
      // with a zero-length entry, and release/verify of bad handles.
      @(negedge clock);
      request_q.push_back(make_req(OP_ACCESS, 8'd0, 16'h0000, 8'd0, 16'd2, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd255, 16'h0000, 8'd0, 16'd2, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h1234, 8'd0, 16'd2, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, ANY_TYPE, 8'd2, 16'd2, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd255, 16'd2, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd1, 16'd9, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd1, 16'hFFFF, '1, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd0, 16'd2,
                                   64'hDEAD_BEEF_0000_0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd0, 16'd2, 64'h0608, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd0, 16'd1, 64'h08, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd0, 16'd2, 64'h0800, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, 16'h0000, 8'd0, 16'd0, 64'h0, 4'd0, 1'b1));
      request_q.push_back(make_req(OP_ACCESS, 8'd1, ANY_TYPE, 8'd1, 16'd8, '1, 4'd15, 1'b0));
      request_q.push_back(make_req(OP_LOCATE, 8'd1, 16'h0, 8'd0, 16'd0,
                                   64'hFFFF_FFFF_FFFF_0608, 4'd0, 1'b0));
      request_q.push_back(make_req(OP_LOCATE, 8'd5, 16'h0, 8'd0, 16'd0, 64'h0, 4'd0, 1'b0));
      request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd2, 1'b0));
      request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd2, 1'b0));
      request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd15, 1'b0));
      request_q.push_back(make_req(OP_LOCATE, 8'd5, 16'h0, 8'd0, 16'd0, 64'h0, 4'd0, 1'b0));
      request_q.push_back(make_req(OP_VERIFY, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd0, 1'b0));
      request_q.push_back(make_req(OP_VERIFY, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd15, 1'b0));
      request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd0, 1'b0));
      request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd1, 1'b0));
      request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0, 4'd3, 1'b0));
      drain();

      // Random part: five register settings, each under four flow-control mixes.
      for (int ph = 0; ph < 5; ph++) begin
         if (ph != 0) begin
            drain();
            repeat (4) @(posedge clock);
            case (ph)
               1: begin  // no class served; widest type and ieee codes
                  write_reg(CSR_OWN_CLASS, 16'd0);
                  write_reg(CSR_OWN_TYPE, 16'hFFFF);
                  write_reg(CSR_IEEE_CLASS, 16'd255);
               end
               2: begin  // own class is the IEEE class
                  write_reg(CSR_OWN_CLASS, 16'd255);
                  write_reg(CSR_OWN_TYPE, 16'hFFFF);
                  write_reg(CSR_IEEE_CLASS, 16'd255);
               end
               3: begin
                  write_reg(CSR_OWN_CLASS, 16'd11);
                  write_reg(CSR_OWN_TYPE, 16'h0800);
                  write_reg(CSR_IEEE_CLASS, 16'd11);
               end
               default: begin
                  write_reg(CSR_OWN_CLASS, 16'd1);
                  write_reg(CSR_OWN_TYPE, 16'd0);
                  write_reg(CSR_IEEE_CLASS, 16'd0);
               end
            endcase
         end
         for (int mode = 0; mode < 4; mode++) begin
            @(negedge clock);
            send_idle_pct = (mode == 1) ? 57 : (mode == 3) ? 34 : 0;
            rsp_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 34 : 0;
            if (mode == 0) begin
               // Offer zero-length claims past the table's size, then release every handle.
               for (int k = 0; k < NUM_H + 2; k++)
                  request_q.push_back(make_req(OP_ACCESS, cfg_own_class, cfg_own_type, 8'd0,
                                               16'd0, {$urandom, $urandom}, 4'd0, 1'b1));
               for (int k = 0; k < NUM_H; k++)
                  request_q.push_back(make_req(OP_RELEASE, 8'd0, 16'h0, 8'd0, 16'd0, 64'h0,
                                               k[HANDLE_W-1:0], 1'b0));
            end
            for (int k = 0; k < BATCH_ITEMS; k++)
               request_q.push_back(random_request());
            // Stall the response side for a long stretch so the input backs up.
            if (ph == 0 && mode == 0)
               hold_requests++;
            drain();
         end
      end

      drain();
      repeat (10) @(posedge clock);
      $display("Summary: %0d responses checked over 5 register settings and 4 flow-control mixes",
               rsp_index);
      $display("  ok %0d, rejected %0d, in use %0d, no space %0d, bad handle %0d, not found %0d",
               status_seen[ST_OK],
               status_seen[ST_NO_CLASS] + status_seen[ST_NO_TYPE] +
               status_seen[ST_NO_NUMBER] + status_seen[ST_BAD_TYPE],
               status_seen[ST_TYPE_INUSE], status_seen[ST_NO_SPACE],
               status_seen[ST_BAD_HANDLE], status_seen[ST_NOT_FOUND]);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
